// ===== rtl/core/gss_pkg.sv =====
// Shared constants, types and saturating arithmetic for the Gauss-Seidel solver.
`default_nettype none

package gss_pkg;

  localparam int N     = 4;
  localparam int COLS  = N + 1;
  localparam int DEPTH = N * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = 2;
  localparam int CW    = 3;

  localparam logic [1:0] WR_SRC_INPUT = 2'd0;
  localparam logic [1:0] WR_SRC_RDATA = 2'd1;
  localparam logic [1:0] WR_SRC_TMP   = 2'd2;

  localparam logic [1:0] STAT_CONVERGED = 2'd0;
  localparam logic [1:0] STAT_LIMIT     = 2'd1;
  localparam logic [1:0] STAT_ZERO_DIAG = 2'd2;

  typedef struct packed {
    logic          rd_en;
    logic [RW-1:0] rd_row;
    logic [CW-1:0] rd_col;
    logic          wr_en;
    logic [RW-1:0] wr_row;
    logic [CW-1:0] wr_col;
    logic [1:0]    wr_src;
    logic          sum_clr;
    logic          sum_acc;
    logic          aij_load;
    logic          tmp_load;
    logic          b_load;
    logic          mul_en;
    logic [RW-1:0] est_idx;
    logic          acc_en;
    logic          acc_lower;
    logic          num1;
    logic          num2;
    logic          div_start;
    logic          div_step;
    logic          est_clr;
    logic          est_wr;
    logic          prev_load;
    logic          out_load;
  } gss_cmd_t;

  typedef struct packed {
    logic swap;
    logic rd_zero;
    logic converged;
  } gss_stat_t;

  function automatic logic signed [63:0] clamp65(input logic signed [64:0] s);
    logic signed [63:0] r;
    if (s[64] != s[63]) begin
      r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      r = s[63:0];
    end
    return r;
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    return clamp65(s);
  endfunction

  function automatic logic signed [63:0] sat_sub64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    return clamp65(s);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gauss_seidel_solver.sv =====
// Loading accepts one coefficient per cycle while idle; the final one starts a solve.
// Row reordering then visits each row pair and swaps rows where needed, then checks the diagonal for zeros.
// Each sweep updates every unknown in turn, dividing by its diagonal in the radix-2 divider.
// The four results then leave one per transfer, each loaded into the output register first.
// Reset clears control state and estimates and sets the registers (tolerance 7, limit 40), not the memory.
`default_nettype none

module gauss_seidel_solver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  row_i,
  input  logic [2:0]  column_i,
  input  logic [31:0] coefficient_i,
  input  logic        final_entry_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  unknown_index_o,
  output logic [31:0] solution_o,
  output logic [7:0]  sweep_count_o,
  output logic [1:0]  status_o,
  output logic        last_result_o
);
  import gss_pkg::*;

  localparam logic CFG_TOLERANCE = 1'b0;
  localparam logic CFG_MAX_ITER  = 1'b1;

  logic [30:0] tolerance_q;
  logic [7:0]  max_iter_q;
  gss_cmd_t    cmd;
  gss_stat_t   stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q <= 31'd7;
      max_iter_q  <= 8'd40;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TOLERANCE: tolerance_q <= cfg_data_i[30:0];
        CFG_MAX_ITER:  max_iter_q  <= cfg_data_i[7:0];
        default:       tolerance_q <= tolerance_q;
      endcase
    end
  end

  gss_controller u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .row_i            (row_i),
    .column_i         (column_i),
    .final_entry_i    (final_entry_i),
    .max_iterations_i (max_iter_q),
    .stat_i           (stat),
    .cmd_o            (cmd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .unknown_index_o  (unknown_index_o),
    .sweep_count_o    (sweep_count_o),
    .status_o         (status_o),
    .last_result_o    (last_result_o)
  );

  gss_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .coefficient_i (coefficient_i),
    .tolerance_i   (tolerance_q),
    .stat_o        (stat),
    .solution_o    (solution_o)
  );

`ifndef SYNTHESIS
  a_no_load_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready during result transfer");

  a_zero_diag_no_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_ZERO_DIAG) |-> (sweep_count_o == 8'd0))
    else $error("sweeps counted on zero diagonal");

  a_limit_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == STAT_LIMIT) |-> (sweep_count_o >= max_iter_q))
    else $error("iteration limit status before the limit");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_result_o) |=> (in_ready_o && !out_valid_o))
    else $error("not idle after the last result transfer");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/gss_datapath.sv =====
// Datapath: coefficient memory, estimates, multiply-accumulate and radix-2 divider.
`default_nettype none

module gss_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gss_pkg::gss_cmd_t cmd_i,
  input  logic [31:0]       coefficient_i,
  input  logic [30:0]       tolerance_i,
  output gss_pkg::gss_stat_t stat_o,
  output logic [31:0]       solution_o
);
  import gss_pkg::*;

  logic [31:0]        mem_q [DEPTH];
  logic [31:0]        rdata_q;
  logic [AW-1:0]      raddr, waddr;
  logic [31:0]        wdata;
  logic [33:0]        sum_q;
  logic [31:0]        aij_q, tmp_q, b_q;
  logic [32:0]        abs_rd, abs_aij;
  logic [33:0]        others;
  logic [31:0]        est_q [N];
  logic [31:0]        prev0_q;
  logic signed [63:0] lower_q, upper_q, num_q, prod_q;
  logic [63:0]        dvd_q;
  logic [31:0]        dsr_q, rem_q;
  logic               neg_q;
  logic [32:0]        shifted, diff, abs_diff;
  logic               ge;
  logic [31:0]        qsat;
  logic [31:0]        sol_q;

  assign raddr = AW'(cmd_i.rd_row) * AW'(COLS) + AW'(cmd_i.rd_col);
  assign waddr = AW'(cmd_i.wr_row) * AW'(COLS) + AW'(cmd_i.wr_col);

  always_comb begin
    case (cmd_i.wr_src)
      WR_SRC_INPUT: wdata = coefficient_i;
      WR_SRC_RDATA: wdata = rdata_q;
      WR_SRC_TMP:   wdata = tmp_q;
      default:      wdata = coefficient_i;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  assign abs_rd  = rdata_q[31] ? (33'd0 - {1'b1, rdata_q}) : {1'b0, rdata_q};
  assign abs_aij = aij_q[31] ? (33'd0 - {1'b1, aij_q}) : {1'b0, aij_q};
  assign others  = sum_q - 34'(abs_aij);

  assign shifted = {rem_q, dvd_q[63]};
  assign ge      = shifted >= {1'b0, dsr_q};

  always_comb begin
    if (neg_q) begin
      qsat = (dvd_q > 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - dvd_q[31:0]);
    end else begin
      qsat = (dvd_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : dvd_q[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum_clr) begin
      sum_q <= '0;
    end else if (cmd_i.sum_acc) begin
      sum_q <= sum_q + 34'(abs_rd);
    end
    if (cmd_i.aij_load) begin
      aij_q <= rdata_q;
    end
    if (cmd_i.tmp_load) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.b_load) begin
      b_q     <= rdata_q;
      lower_q <= '0;
      upper_q <= '0;
    end else if (cmd_i.acc_en) begin
      if (cmd_i.acc_lower) begin
        lower_q <= sat_add64(lower_q, prod_q);
      end else begin
        upper_q <= sat_add64(upper_q, prod_q);
      end
    end
    if (cmd_i.mul_en) begin
      prod_q <= $signed(rdata_q) * $signed(est_q[cmd_i.est_idx]);
    end
    if (cmd_i.num1) begin
      num_q <= sat_sub64($signed({b_q, 32'd0}), lower_q);
    end else if (cmd_i.num2) begin
      num_q <= sat_sub64(num_q, upper_q);
    end
    if (cmd_i.div_start) begin
      dvd_q <= num_q[63] ? (64'd0 - num_q) : num_q;
      dsr_q <= rdata_q[31] ? (32'd0 - rdata_q) : rdata_q;
      neg_q <= num_q[63] ^ rdata_q[31];
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= ge ? 32'(shifted - {1'b0, dsr_q}) : shifted[31:0];
      dvd_q <= {dvd_q[62:0], ge};
    end
    if (cmd_i.out_load) begin
      sol_q <= est_q[cmd_i.est_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < N; k++) begin
        est_q[k] <= '0;
      end
      prev0_q <= '0;
    end else if (cmd_i.est_clr) begin
      for (int k = 0; k < N; k++) begin
        est_q[k] <= '0;
      end
      prev0_q <= '0;
    end else begin
      if (cmd_i.est_wr) begin
        est_q[cmd_i.est_idx] <= qsat;
      end
      if (cmd_i.prev_load) begin
        prev0_q <= est_q[0];
      end
    end
  end

  assign diff     = {est_q[0][31], est_q[0]} - {prev0_q[31], prev0_q};
  assign abs_diff = diff[32] ? (33'd0 - diff) : diff;

  assign stat_o.swap      = !aij_q[31] && (34'(aij_q) > others);
  assign stat_o.rd_zero   = (rdata_q == 32'd0);
  assign stat_o.converged = abs_diff <= 33'(tolerance_i);
  assign solution_o       = sol_q;

endmodule

`default_nettype wire

// ===== rtl/core/gss_controller.sv =====
// Controller: sequences loading, row reordering, sweeps and result transfers.
`default_nettype none

module gss_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         row_i,
  input  logic [2:0]         column_i,
  input  logic               final_entry_i,
  input  logic [7:0]         max_iterations_i,
  input  gss_pkg::gss_stat_t stat_i,
  output gss_pkg::gss_cmd_t  cmd_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         unknown_index_o,
  output logic [7:0]         sweep_count_o,
  output logic [1:0]         status_o,
  output logic               last_result_o
);
  import gss_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RS_RD    = 5'd1;
  localparam logic [4:0] S_RS_ACC   = 5'd2;
  localparam logic [4:0] S_RS_CMP   = 5'd3;
  localparam logic [4:0] S_XCH_RDJ  = 5'd4;
  localparam logic [4:0] S_XCH_RDI  = 5'd5;
  localparam logic [4:0] S_XCH_WJ   = 5'd6;
  localparam logic [4:0] S_XCH_WI   = 5'd7;
  localparam logic [4:0] S_NEXT     = 5'd8;
  localparam logic [4:0] S_DG_RD    = 5'd9;
  localparam logic [4:0] S_DG_CHK   = 5'd10;
  localparam logic [4:0] S_SWEEP    = 5'd11;
  localparam logic [4:0] S_B_RD     = 5'd12;
  localparam logic [4:0] S_B_LD     = 5'd13;
  localparam logic [4:0] S_P_RD     = 5'd14;
  localparam logic [4:0] S_P_MUL    = 5'd15;
  localparam logic [4:0] S_P_ACC    = 5'd16;
  localparam logic [4:0] S_NUM1     = 5'd17;
  localparam logic [4:0] S_NUM2     = 5'd18;
  localparam logic [4:0] S_D_RD     = 5'd19;
  localparam logic [4:0] S_DIV_ST   = 5'd20;
  localparam logic [4:0] S_DIV      = 5'd21;
  localparam logic [4:0] S_EST_WR   = 5'd22;
  localparam logic [4:0] S_CHK      = 5'd23;
  localparam logic [4:0] S_OUT_LD   = 5'd24;
  localparam logic [4:0] S_OUT_WAIT = 5'd25;

  localparam logic [RW-1:0] LAST_IDX = RW'(N - 1);
  localparam logic [CW-1:0] RHS_COL  = CW'(N);

  logic [4:0]    state_q, state_d;
  logic [RW-1:0] i_q, i_d, j_q, j_d;
  logic [CW-1:0] c_q, c_d;
  logic [5:0]    cnt_q, cnt_d;
  logic [7:0]    sweep_q, sweep_d;
  logic [1:0]    status_q, status_d;
  logic          zero_q, zero_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      i_q      <= '0;
      j_q      <= '0;
      c_q      <= '0;
      cnt_q    <= '0;
      sweep_q  <= '0;
      status_q <= STAT_CONVERGED;
      zero_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      c_q      <= c_d;
      cnt_q    <= cnt_d;
      sweep_q  <= sweep_d;
      status_q <= status_d;
      zero_q   <= zero_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    c_d      = c_q;
    cnt_d    = cnt_q;
    sweep_d  = sweep_q;
    status_d = status_q;
    zero_d   = zero_q;
    cmd_o    = '0;
    cmd_o.est_idx = i_q;
    in_ready_o = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.wr_row = row_i;
        cmd_o.wr_col = column_i;
        cmd_o.wr_src = WR_SRC_INPUT;
        if (in_valid_i) begin
          cmd_o.wr_en = (column_i <= RHS_COL);
          if (final_entry_i) begin
            cmd_o.sum_clr = 1'b1;
            i_d     = '0;
            j_d     = '0;
            c_d     = '0;
            state_d = S_RS_RD;
          end
        end
      end
      S_RS_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_row = i_q;
        cmd_o.rd_col = c_q;
        state_d      = S_RS_ACC;
      end
      S_RS_ACC: begin
        cmd_o.sum_acc  = 1'b1;
        cmd_o.aij_load = (c_q == CW'(j_q));
        if (c_q == CW'(LAST_IDX)) begin
          state_d = S_RS_CMP;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_RS_RD;
        end
      end
      S_RS_CMP: begin
        c_d     = '0;
        state_d = stat_i.swap ? S_XCH_RDJ : S_NEXT;
      end
      S_XCH_RDJ: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_row = j_q;
        cmd_o.rd_col = c_q;
        state_d      = S_XCH_RDI;
      end
      S_XCH_RDI: begin
        cmd_o.tmp_load = 1'b1;
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_row   = i_q;
        cmd_o.rd_col   = c_q;
        state_d        = S_XCH_WJ;
      end
      S_XCH_WJ: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_row = j_q;
        cmd_o.wr_col = c_q;
        cmd_o.wr_src = WR_SRC_RDATA;
        state_d      = S_XCH_WI;
      end
      S_XCH_WI: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_row = i_q;
        cmd_o.wr_col = c_q;
        cmd_o.wr_src = WR_SRC_TMP;
        if (c_q == RHS_COL) begin
          state_d = S_NEXT;
        end else begin
          c_d     = c_q + 1'b1;
          state_d = S_XCH_RDJ;
        end
      end
      S_NEXT: begin
        cmd_o.sum_clr = 1'b1;
        c_d = '0;
        if (i_q == LAST_IDX) begin
          i_d = '0;
          if (j_q == LAST_IDX) begin
            zero_d  = 1'b0;
            state_d = S_DG_RD;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_RS_RD;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_RS_RD;
        end
      end
      S_DG_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_row = i_q;
        cmd_o.rd_col = CW'(i_q);
        state_d      = S_DG_CHK;
      end
      S_DG_CHK: begin
        zero_d = zero_q | stat_i.rd_zero;
        if (i_q == LAST_IDX) begin
          cmd_o.est_clr = 1'b1;
          sweep_d = '0;
          i_d     = '0;
          if (zero_q || stat_i.rd_zero) begin
            status_d = STAT_ZERO_DIAG;
            state_d  = S_OUT_LD;
          end else begin
            state_d = S_SWEEP;
          end
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_DG_RD;
        end
      end
      S_SWEEP: begin
        cmd_o.prev_load = 1'b1;
        sweep_d = sweep_q + 1'b1;
        i_d     = '0;
        state_d = S_B_RD;
      end
      S_B_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_row = i_q;
        cmd_o.rd_col = RHS_COL;
        state_d      = S_B_LD;
      end
      S_B_LD: begin
        cmd_o.b_load = 1'b1;
        j_d     = '0;
        state_d = S_P_RD;
      end
      S_P_RD: begin
        if (j_q == i_q) begin
          if (j_q == LAST_IDX) begin
            state_d = S_NUM1;
          end else begin
            j_d = j_q + 1'b1;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_row = i_q;
          cmd_o.rd_col = CW'(j_q);
          state_d      = S_P_MUL;
        end
      end
      S_P_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.est_idx = j_q;
        state_d       = S_P_ACC;
      end
      S_P_ACC: begin
        cmd_o.acc_en    = 1'b1;
        cmd_o.acc_lower = (j_q < i_q);
        if (j_q == LAST_IDX) begin
          state_d = S_NUM1;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = S_P_RD;
        end
      end
      S_NUM1: begin
        cmd_o.num1 = 1'b1;
        state_d    = S_NUM2;
      end
      S_NUM2: begin
        cmd_o.num2 = 1'b1;
        state_d    = S_D_RD;
      end
      S_D_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_row = i_q;
        cmd_o.rd_col = CW'(i_q);
        state_d      = S_DIV_ST;
      end
      S_DIV_ST: begin
        cmd_o.div_start = 1'b1;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 6'd63) begin
          state_d = S_EST_WR;
        end
      end
      S_EST_WR: begin
        cmd_o.est_wr = 1'b1;
        if (i_q == LAST_IDX) begin
          state_d = S_CHK;
        end else begin
          i_d     = i_q + 1'b1;
          state_d = S_B_RD;
        end
      end
      S_CHK: begin
        i_d = '0;
        if (stat_i.converged) begin
          status_d = STAT_CONVERGED;
          state_d  = S_OUT_LD;
        end else if (sweep_q >= max_iterations_i) begin
          status_d = STAT_LIMIT;
          state_d  = S_OUT_LD;
        end else begin
          state_d = S_SWEEP;
        end
      end
      S_OUT_LD: begin
        cmd_o.out_load = 1'b1;
        state_d        = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        if (out_ready_i) begin
          if (i_q == LAST_IDX) begin
            i_d     = '0;
            state_d = S_IDLE;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_OUT_LD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_o     = (state_q == S_OUT_WAIT);
  assign unknown_index_o = i_q;
  assign sweep_count_o   = sweep_q;
  assign status_o        = status_q;
  assign last_result_o   = (i_q == LAST_IDX);

endmodule

`default_nettype wire
